// ===== rtl/arcs_pkg.sv =====
// arcs_pkg: shared types and constants for the contrast stretch block
// (abs_range_contrast_stretch_sqrt). No dependencies.
`default_nettype none

package arcs_pkg;

   localparam int PIXEL_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 8;

   localparam int THRESH_W           = 12;
   localparam logic [11:0] THRESH_RST = 12'd255;

   localparam int OUT_W      = 20;
   localparam int RSP_DATA_W = ((OUT_W + 7) / 8) * 8;

   // req_tuser bit positions
   localparam int USER_OP    = 0;
   localparam int USER_FIRST = 1;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_ENHANCE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NUMER,
      ST_DIV,
      ST_CLAMP,
      ST_SQMUL,
      ST_ROOT,
      ST_FINISH
   } state_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/abs_range_contrast_stretch_sqrt.sv =====
// Contrast stretch with square-root gamma: range tracking, plus a stretch divide
// and a square root on one shared subtractor. Depends on arcs_pkg.
//
// Usage:
//   req_*  : input stream. tuser[0] = operation (0 measure, 1 enhance),
//            tuser[1] = first (restart the range on a measure transaction),
//            tdata = signed pixel, Q(PIXEL_BITS-FRAC_BITS).FRAC_BITS.
//   rsp_*  : one transaction per enhance input, tdata = unsigned Q12.8 result.
//   csr_*  : writes thresh (12 bits, reset 255); always ready, write only
//            while the block is idle.
// Timing:
//   measure transactions are absorbed in the accept cycle, one per clock while idle.
//   an enhance transaction keeps req_tready low until its result is loaded
//   into the output register: direct mapping runs the square multiply, the
//   root iteration and the final step; stretch mapping adds a multiply, a
//   restoring divide of PIXEL_BITS+13 steps and a clamp. The divide and
//   the root iterate one bit (one root digit) per cycle through the single
//   shared subtractor.
// Reset: synchronous; thresh returns to 255, the range to zero, no result
//   pending. A stalled rsp_tready holds the result in the output register and
//   the next enhance transaction waits in the final step until it drains.
`default_nettype none

module abs_range_contrast_stretch_sqrt #(
   parameter int PIXEL_BITS = arcs_pkg::PIXEL_BITS_DEF,
   parameter int FRAC_BITS  = arcs_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0]  req_tdata,  // [PIXEL_BITS-1:0] pixel
   input  logic [1:0]                             req_tuser,  // [0] operation, [1] first
   // response stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [arcs_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // [19:0] enhanced
   // threshold register write
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [arcs_pkg::THRESH_W-1:0]          csr_data
);
   import arcs_pkg::*;

   localparam int P    = PIXEL_BITS;
   localparam int F    = FRAC_BITS;
   localparam int NW   = P + 13;                    // stretch numerator / quotient
   localparam int RW   = THRESH_W + F;              // root width
   localparam int XW   = 2 * RW;                    // radicand width
   localparam int SW   = max_int(P + 1, RW + 3);    // shared subtractor width
   localparam int CMPW = max_int(P, THRESH_W + F);
   localparam int CW   = $clog2(max_int(NW, RW));
   localparam logic [P:0] HALF = (P + 1)'((64'd1 << F) >> 1);

   state_type state_ff, state_in;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [P-1:0]        low_ff, low_in;
   logic [P-1:0]        high_ff, high_in;
   logic [P:0]          d_ff, d_in;
   logic [P-1:0]        den_ff, den_in;
   logic [NW-1:0]       num_ff, num_in;
   logic [SW-1:0]       rem_ff, rem_in;
   logic [THRESH_W-1:0] v_ff, v_in;
   logic [XW-1:0]       x_ff, x_in;
   logic [RW-1:0]       root_ff, root_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic signed [P-1:0] pixel;
   logic [P-1:0]        pix_abs;
   logic [P:0]          pix_diff;
   logic [P:0]          dir_sum;
   logic [P:0]          dir_v;
   logic                stretch;
   logic                out_free;

   // shared subtract unit
   logic [SW-1:0]       op_a, op_b;
   logic [SW:0]         diff;
   logic                take;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign pixel    = signed'(req_tdata[P-1:0]);
   assign pix_abs  = pixel[P-1] ? P'(-pixel) : P'(pixel);
   assign pix_diff = (P + 1)'({pixel[P-1], pixel} - {1'b0, low_ff});
   assign dir_sum  = {1'b0, pix_abs} + HALF;
   assign dir_v    = dir_sum >> F;
   assign stretch  = CMPW'(high_ff) > (CMPW'(thresh_ff) << F);

   always_comb begin
      if (state_ff == ST_DIV) begin
         op_a = {rem_ff[SW-2:0], num_ff[NW-1]};
         op_b = SW'({den_ff, 1'b0});
      end else begin
         op_a = {rem_ff[SW-3:0], x_ff[XW-1:XW-2]};
         op_b = SW'({root_ff, 2'b01});
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      take = !diff[SW];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser[USER_OP] == OP_ENHANCE) begin
               if (stretch && high_ff > low_ff) begin
                  state_in = ST_NUMER;
               end else begin
                  state_in = ST_SQMUL;
               end
            end
         end
         ST_NUMER:  state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == '0) state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_SQMUL;
         ST_SQMUL:  state_in = ST_ROOT;
         ST_ROOT:   if (cnt_ff == '0) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      thresh_in    = thresh_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      d_in         = d_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      v_in         = v_ff;
      x_in         = x_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         thresh_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[USER_OP] == OP_MEASURE) begin
                  if (req_tuser[USER_FIRST]) begin
                     low_in  = pix_abs;
                     high_in = pix_abs;
                  end else begin
                     if (pix_abs < low_ff)  low_in  = pix_abs;
                     if (pix_abs > high_ff) high_in = pix_abs;
                  end
               end else begin
                  d_in   = pix_diff[P] ? (P + 1)'(-pix_diff) : pix_diff;
                  den_in = high_ff - low_ff;
                  if (stretch) begin
                     // empty range maps to zero
                     v_in = '0;
                  end else if (dir_v > (P + 1)'(thresh_ff)) begin
                     v_in = thresh_ff;
                  end else begin
                     v_in = THRESH_W'(dir_v);
                  end
               end
            end
         end
         ST_NUMER: begin
            // round half up: (2*thresh*d + den) / (2*den)
            num_in = ((NW'(thresh_ff) * NW'(d_ff)) << 1) + NW'(den_ff);
            rem_in = '0;
            cnt_in = CW'(NW - 1);
         end
         ST_DIV: begin
            rem_in = take ? diff[SW-1:0] : op_a;
            num_in = {num_ff[NW-2:0], take};
            cnt_in = cnt_ff - 1'b1;
         end
         ST_CLAMP: begin
            v_in = (num_ff > NW'(thresh_ff)) ? thresh_ff : THRESH_W'(num_ff);
         end
         ST_SQMUL: begin
            x_in    = (XW'(thresh_ff) * XW'(v_ff)) << (2 * F);
            rem_in  = '0;
            root_in = '0;
            cnt_in  = CW'(RW - 1);
         end
         ST_ROOT: begin
            rem_in  = take ? diff[SW-1:0] : op_a;
            root_in = {root_ff[RW-2:0], take};
            x_in    = x_ff << 2;
            cnt_in  = cnt_ff - 1'b1;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_W'(root_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RST;
         low_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff        <= d_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      v_ff        <= v_in;
      x_ff        <= x_in;
      root_ff     <= root_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
